@@ rtl/msi_directory_controller_defines.svh @@
// assertion macros for the port checker file
`ifndef MSI_DIRECTORY_CONTROLLER_DEFINES_SVH
`define MSI_DIRECTORY_CONTROLLER_DEFINES_SVH

// check on aclk, quiet while aresetn is low
`define MSIDC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check on aclk, also through reset
`define MSIDC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ rtl/msidc_pkg.sv @@
// types and constants of the msi directory controller
`timescale 1ns / 1ps

package msidc_pkg;

    localparam int NUM_LINES  = 1024;
    localparam int NUM_AGENTS = 8;
    localparam int LINE_W     = $clog2(NUM_LINES);
    localparam int AGENT_W    = 3;
    localparam int SCAN_W     = $clog2(NUM_AGENTS);

    typedef logic [NUM_AGENTS-1:0] agent_vec_t;

    typedef enum logic [1:0] {
        DIR_I,
        DIR_S,
        DIR_M,
        DIR_SD
    } dir_state_t;

    typedef enum logic [2:0] {
        FUNC_GETS,
        FUNC_GETM,
        FUNC_PUTS,
        FUNC_PUTM,
        FUNC_DATA
    } func_t;

    typedef enum logic [1:0] {
        VERDICT_ADVANCED,
        VERDICT_STALLED,
        VERDICT_UNEXPECTED
    } verdict_t;

    typedef enum logic [2:0] {
        MSG_NONE,
        MSG_DATA,
        MSG_INV,
        MSG_FWDGETS,
        MSG_FWDGETM,
        MSG_PUTSACK,
        MSG_PUTMACK
    } msg_kind_t;

    typedef enum logic [2:0] {
        SEQ_CLEAR,
        SEQ_IDLE,
        SEQ_EVAL,
        SEQ_SEND,
        SEQ_SCAN
    } seq_state_t;

    typedef struct packed {
        dir_state_t         state;
        agent_vec_t         sharers;
        logic [AGENT_W-1:0] owner;
        logic               owner_valid;
    } dir_entry_t;

    typedef struct packed {
        logic              we;
        logic [LINE_W-1:0] waddr;
        dir_entry_t        wdata;
        logic              re;
        logic [LINE_W-1:0] raddr;
    } ram_ctrl_t;

endpackage

@@ rtl/msidc_dir_ram.sv @@
// directory entry memory, one write and one registered read port
`timescale 1ns / 1ps

module msidc_dir_ram (
    input  logic                  aclk,
    input  msidc_pkg::ram_ctrl_t  ctrl,
    output msidc_pkg::dir_entry_t rd_data
);

    msidc_pkg::dir_entry_t mem [msidc_pkg::NUM_LINES];

    always_ff @(posedge aclk) begin
        if (ctrl.we) begin
            mem[ctrl.waddr] <= ctrl.wdata;
        end
        if (ctrl.re) begin
            rd_data <= mem[ctrl.raddr];
        end
    end

endmodule

@@ rtl/msi_directory_controller.sv @@
// msi directory controller top level
//
// channel  dir  handshake          payload
// s_       in   s_valid/s_ready    s_func, s_line_index, s_requester
// m_       out  m_valid/m_ready    m_verdict, m_msg_kind, m_dest_agent, m_last
//
// a request passes an accept state, an entry lookup/update state, then a send state
// per result that holds while m_ready is low; an invalidation run scans each
// agent id from zero up to the highest sharer, set by the sharer scan counter
// after reset a clearing pass over all 1024 lines zeroes the directory memory,
// s_ready stays low until it ends
// m_ready low holds the current result and keeps s_ready low
`timescale 1ns / 1ps

module msi_directory_controller (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_func,
    input  logic [9:0] s_line_index,
    input  logic [2:0] s_requester,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_verdict,
    output logic [2:0] m_msg_kind,
    output logic [2:0] m_dest_agent,
    output logic       m_last
);

    msidc_pkg::seq_state_t state_reg, state_next;

    logic [msidc_pkg::LINE_W-1:0]  clr_cnt_reg, clr_cnt_next;
    msidc_pkg::func_t              func_reg, func_next;
    logic [msidc_pkg::LINE_W-1:0]  line_reg, line_next;
    logic [msidc_pkg::AGENT_W-1:0] req_reg, req_next;
    msidc_pkg::agent_vec_t         pend_reg, pend_next;
    logic [msidc_pkg::SCAN_W-1:0]  scan_reg, scan_next;

    logic                          m_valid_reg, m_valid_next;
    msidc_pkg::verdict_t           m_verdict_reg, m_verdict_next;
    msidc_pkg::msg_kind_t          m_msg_kind_reg, m_msg_kind_next;
    logic [msidc_pkg::AGENT_W-1:0] m_dest_agent_reg, m_dest_agent_next;
    logic                          m_last_reg, m_last_next;

    msidc_pkg::ram_ctrl_t          ram_ctrl;
    msidc_pkg::dir_entry_t         rd_entry;

    msidc_pkg::dir_entry_t         ev_entry;
    msidc_pkg::verdict_t           ev_verdict;
    msidc_pkg::msg_kind_t          ev_kind;
    logic [msidc_pkg::AGENT_W-1:0] ev_dest;
    msidc_pkg::agent_vec_t         ev_inv;
    msidc_pkg::agent_vec_t         ev_rbit;
    msidc_pkg::agent_vec_t         ev_obit;
    msidc_pkg::agent_vec_t         ev_sh;
    logic                          ev_is_owner;
    logic                          ev_bad;
    msidc_pkg::agent_vec_t         scan_bit;

    msidc_dir_ram u_ram (
        .aclk    (aclk),
        .ctrl    (ram_ctrl),
        .rd_data (rd_entry)
    );

    // entry update for the looked-up line
    always_comb begin
        ev_entry    = rd_entry;
        ev_verdict  = msidc_pkg::VERDICT_ADVANCED;
        ev_kind     = msidc_pkg::MSG_NONE;
        ev_dest     = req_reg;
        ev_inv      = '0;
        ev_rbit     = msidc_pkg::agent_vec_t'(1) << req_reg;
        ev_obit     = msidc_pkg::agent_vec_t'(1) << rd_entry.owner;
        ev_sh       = rd_entry.sharers;
        ev_is_owner = rd_entry.owner_valid && (rd_entry.owner == req_reg);
        ev_bad      = ({1'b0, line_reg} >= (msidc_pkg::LINE_W + 1)'(msidc_pkg::NUM_LINES))
                   || ({1'b0, req_reg} >= (msidc_pkg::AGENT_W + 1)'(msidc_pkg::NUM_AGENTS));
        case (func_reg)
            msidc_pkg::FUNC_GETS: begin
                case (rd_entry.state)
                    msidc_pkg::DIR_I, msidc_pkg::DIR_S: begin
                        ev_kind          = msidc_pkg::MSG_DATA;
                        ev_entry.sharers = ev_sh | ev_rbit;
                        ev_entry.state   = msidc_pkg::DIR_S;
                    end
                    msidc_pkg::DIR_M: begin
                        ev_kind              = msidc_pkg::MSG_FWDGETS;
                        ev_dest              = rd_entry.owner;
                        ev_entry.sharers     = ev_sh | ev_rbit | ev_obit;
                        ev_entry.owner_valid = 1'b0;
                        ev_entry.state       = msidc_pkg::DIR_SD;
                    end
                    default: begin
                        ev_verdict = msidc_pkg::VERDICT_STALLED;
                    end
                endcase
            end
            msidc_pkg::FUNC_GETM: begin
                case (rd_entry.state)
                    msidc_pkg::DIR_I: begin
                        ev_kind              = msidc_pkg::MSG_DATA;
                        ev_entry.owner       = req_reg;
                        ev_entry.owner_valid = 1'b1;
                        ev_entry.state       = msidc_pkg::DIR_M;
                    end
                    msidc_pkg::DIR_S: begin
                        ev_kind              = msidc_pkg::MSG_DATA;
                        ev_inv               = ev_sh;
                        ev_entry.sharers     = '0;
                        ev_entry.owner       = req_reg;
                        ev_entry.owner_valid = 1'b1;
                        ev_entry.state       = msidc_pkg::DIR_M;
                    end
                    msidc_pkg::DIR_M: begin
                        ev_kind              = msidc_pkg::MSG_FWDGETM;
                        ev_dest              = rd_entry.owner;
                        ev_entry.owner       = req_reg;
                        ev_entry.owner_valid = 1'b1;
                    end
                    default: begin
                        ev_verdict = msidc_pkg::VERDICT_STALLED;
                    end
                endcase
            end
            msidc_pkg::FUNC_PUTS: begin
                ev_kind = msidc_pkg::MSG_PUTSACK;
                if (rd_entry.state != msidc_pkg::DIR_I) begin
                    ev_entry.sharers = ev_sh & ~ev_rbit;
                    if (rd_entry.state == msidc_pkg::DIR_S && (ev_sh & ~ev_rbit) == '0) begin
                        ev_entry.state = msidc_pkg::DIR_I;
                    end
                end
            end
            msidc_pkg::FUNC_PUTM: begin
                if (ev_is_owner) begin
                    if (rd_entry.state == msidc_pkg::DIR_M) begin
                        ev_kind              = msidc_pkg::MSG_PUTMACK;
                        ev_entry.owner_valid = 1'b0;
                        ev_entry.state       = msidc_pkg::DIR_I;
                    end else begin
                        ev_verdict = msidc_pkg::VERDICT_UNEXPECTED;
                    end
                end else begin
                    ev_kind = msidc_pkg::MSG_PUTMACK;
                    if (rd_entry.state == msidc_pkg::DIR_S || rd_entry.state == msidc_pkg::DIR_SD) begin
                        ev_entry.sharers = ev_sh & ~ev_rbit;
                    end
                end
            end
            msidc_pkg::FUNC_DATA: begin
                if (rd_entry.state == msidc_pkg::DIR_SD) begin
                    ev_entry.state = msidc_pkg::DIR_S;
                end else begin
                    ev_verdict = msidc_pkg::VERDICT_UNEXPECTED;
                end
            end
            default: begin
                ev_verdict = msidc_pkg::VERDICT_UNEXPECTED;
            end
        endcase
        if (ev_bad) begin
            ev_verdict = msidc_pkg::VERDICT_UNEXPECTED;
        end
        if (ev_verdict != msidc_pkg::VERDICT_ADVANCED) begin
            ev_kind  = msidc_pkg::MSG_NONE;
            ev_inv   = '0;
            ev_entry = rd_entry;
        end
        if (ev_kind == msidc_pkg::MSG_NONE) begin
            ev_dest = '0;
        end
    end

    assign scan_bit = msidc_pkg::agent_vec_t'(1) << scan_reg;

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            msidc_pkg::SEQ_CLEAR: begin
                if (clr_cnt_reg == msidc_pkg::LINE_W'(msidc_pkg::NUM_LINES - 1)) begin
                    state_next = msidc_pkg::SEQ_IDLE;
                end
            end
            msidc_pkg::SEQ_IDLE: begin
                if (s_valid) begin
                    state_next = msidc_pkg::SEQ_EVAL;
                end
            end
            msidc_pkg::SEQ_EVAL: begin
                state_next = msidc_pkg::SEQ_SEND;
            end
            msidc_pkg::SEQ_SEND: begin
                if (m_ready) begin
                    state_next = m_last_reg ? msidc_pkg::SEQ_IDLE : msidc_pkg::SEQ_SCAN;
                end
            end
            msidc_pkg::SEQ_SCAN: begin
                if (pend_reg[scan_reg]) begin
                    state_next = msidc_pkg::SEQ_SEND;
                end
            end
            default: begin
                state_next = msidc_pkg::SEQ_CLEAR;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready           = 1'b0;
        ram_ctrl          = '0;
        clr_cnt_next      = clr_cnt_reg;
        func_next         = func_reg;
        line_next         = line_reg;
        req_next          = req_reg;
        pend_next         = pend_reg;
        scan_next         = scan_reg;
        m_valid_next      = m_valid_reg;
        m_verdict_next    = m_verdict_reg;
        m_msg_kind_next   = m_msg_kind_reg;
        m_dest_agent_next = m_dest_agent_reg;
        m_last_next       = m_last_reg;
        case (state_reg)
            msidc_pkg::SEQ_CLEAR: begin
                ram_ctrl.we    = 1'b1;
                ram_ctrl.waddr = clr_cnt_reg;
                clr_cnt_next   = clr_cnt_reg + 1'b1;
            end
            msidc_pkg::SEQ_IDLE: begin
                s_ready        = 1'b1;
                ram_ctrl.re    = 1'b1;
                ram_ctrl.raddr = s_line_index;
                if (s_valid) begin
                    func_next = msidc_pkg::func_t'(s_func);
                    line_next = s_line_index;
                    req_next  = s_requester;
                end
            end
            msidc_pkg::SEQ_EVAL: begin
                ram_ctrl.we       = (ev_verdict == msidc_pkg::VERDICT_ADVANCED);
                ram_ctrl.waddr    = line_reg;
                ram_ctrl.wdata    = ev_entry;
                m_valid_next      = 1'b1;
                m_verdict_next    = ev_verdict;
                m_msg_kind_next   = ev_kind;
                m_dest_agent_next = ev_dest;
                m_last_next       = (ev_inv == '0);
                pend_next         = ev_inv;
                scan_next         = '0;
            end
            msidc_pkg::SEQ_SEND: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                end
            end
            msidc_pkg::SEQ_SCAN: begin
                scan_next = scan_reg + 1'b1;
                if (pend_reg[scan_reg]) begin
                    m_valid_next      = 1'b1;
                    m_msg_kind_next   = msidc_pkg::MSG_INV;
                    m_dest_agent_next = msidc_pkg::AGENT_W'(scan_reg);
                    m_last_next       = ((pend_reg & ~scan_bit) == '0);
                    pend_next         = pend_reg & ~scan_bit;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= msidc_pkg::SEQ_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg         <= func_next;
        line_reg         <= line_next;
        req_reg          <= req_next;
        pend_reg         <= pend_next;
        scan_reg         <= scan_next;
        m_verdict_reg    <= m_verdict_next;
        m_msg_kind_reg   <= m_msg_kind_next;
        m_dest_agent_reg <= m_dest_agent_next;
        m_last_reg       <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_verdict    = m_verdict_reg;
    assign m_msg_kind   = m_msg_kind_reg;
    assign m_dest_agent = m_dest_agent_reg;
    assign m_last       = m_last_reg;

endmodule

@@ rtl/msidc_checker.sv @@
// port checker for the msi directory controller, bound to the top level
`timescale 1ns / 1ps
`include "msi_directory_controller_defines.svh"

module msidc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_verdict,
    input logic [2:0] m_msg_kind,
    input logic [2:0] m_dest_agent,
    input logic       m_last
);

    logic [8:0] m_payload;
    logic       m_stall;
    logic       m_blocked;
    logic       m_empty;

    assign m_payload = {m_verdict, m_msg_kind, m_dest_agent, m_last};
    assign m_stall   = m_valid && !m_ready;
    assign m_blocked = m_valid && (m_verdict != msidc_pkg::VERDICT_ADVANCED);
    assign m_empty   = m_last && (m_msg_kind == msidc_pkg::MSG_NONE) && (m_dest_agent == '0);

    // a held result keeps its payload
    `MSIDC_ASSERT(a_m_hold, m_stall |=> m_valid && $stable(m_payload), "result not held")

    // no new request while a result waits
    `MSIDC_ASSERT(a_busy_out, m_valid |-> !s_ready, "request taken while result pending")

    // a request is never followed by another in the next cycle
    `MSIDC_ASSERT(a_one_req, s_valid && s_ready |=> !s_ready, "back to back request")

    // stalled or rejected requests give a single empty result
    `MSIDC_ASSERT(a_verdict_single, m_blocked |-> m_empty, "bad result for non-advanced request")

    // reset empties both channels
    `MSIDC_ASSERT_RST(a_reset, !aresetn |=> !m_valid && !s_ready, "channel active after reset")

endmodule

bind msi_directory_controller msidc_checker u_msidc_checker (.*);

@@ tb/tb_top.sv @@
// self-checking testbench of the msi directory controller: mirrored directory, random traffic
`timescale 1ns / 1ps

module tb_top;
    import msidc_pkg::*;

    localparam int        SETTLE_CYCLES = 16;
    localparam int        HOLD_CYCLES   = 300;
    localparam logic [9:0] LINE_LO  = 10'd0;
    localparam logic [9:0] LINE_HI  = 10'd1023;
    localparam logic [9:0] LINE_MID = 10'd512;

    typedef struct {
        verdict_t   verdict;
        msg_kind_t  kind;
        logic [2:0] dest;
        logic       last;
    } dir_msg_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [2:0] s_func;
    logic [9:0] s_line_index;
    logic [2:0] s_requester;
    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_verdict;
    logic [2:0] m_msg_kind;
    logic [2:0] m_dest_agent;
    logic       m_last;

    dir_state_t  mirror_state    [NUM_LINES];
    agent_vec_t  mirror_sharers  [NUM_LINES];
    logic [2:0]  mirror_owner    [NUM_LINES];
    logic        mirror_owner_ok [NUM_LINES];
    dir_msg_t    expected_msgs [$];
    logic [9:0]  line_pool [6] = '{10'd0, 10'd1, 10'd2, 10'd341, 10'd512, 10'd1023};

    bit src_idle  = 1'b1;
    bit sink_idle = 1'b1;
    int sink_stall = 0;
    int sink_hold  = 0;
    int n_errors   = 0;
    int n_requests = 0;
    int n_results  = 0;
    int n_inv      = 0;
    int n_stall    = 0;
    int n_unexp    = 0;
    int run_len    = 0;
    int max_run    = 0;

    msi_directory_controller dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_line_index (s_line_index),
        .s_requester  (s_requester),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_verdict    (m_verdict),
        .m_msg_kind   (m_msg_kind),
        .m_dest_agent (m_dest_agent),
        .m_last       (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("msi_directory_controller test failed");
        $finish;
    end

    function automatic void predict_directory(input logic [2:0] f, input logic [9:0] line,
                                              input logic [2:0] req);
        dir_state_t st;
        agent_vec_t sh;
        agent_vec_t rbit;
        logic [2:0] own;
        logic       own_ok;
        logic       is_owner;
        verdict_t   v;
        msg_kind_t  kinds [$];
        logic [2:0] dests [$];
        dir_msg_t   m;
        st       = mirror_state[line];
        sh       = mirror_sharers[line];
        own      = mirror_owner[line];
        own_ok   = mirror_owner_ok[line];
        is_owner = own_ok && (own == req);
        rbit     = agent_vec_t'(1) << req;
        v        = VERDICT_ADVANCED;
        case (f)
            FUNC_GETS: begin
                case (st)
                    DIR_I, DIR_S: begin
                        kinds = {kinds, MSG_DATA};
                        dests = {dests, req};
                        sh |= rbit;
                        st = DIR_S;
                    end
                    DIR_M: begin
                        kinds  = {kinds, MSG_FWDGETS};
                        dests  = {dests, own};
                        sh     = sh | rbit | (agent_vec_t'(1) << own);
                        own_ok = 1'b0;
                        st     = DIR_SD;
                    end
                    default: v = VERDICT_STALLED;
                endcase
            end
            FUNC_GETM: begin
                case (st)
                    DIR_I, DIR_S: begin
                        kinds = {kinds, MSG_DATA};
                        dests = {dests, req};
                        if (st == DIR_S) begin
                            for (int a = 0; a < NUM_AGENTS; a++) begin
                                if (sh[a]) begin
                                    kinds = {kinds, MSG_INV};
                                    dests = {dests, 3'(a)};
                                end
                            end
                            sh = '0;
                        end
                        own    = req;
                        own_ok = 1'b1;
                        st     = DIR_M;
                    end
                    DIR_M: begin
                        kinds  = {kinds, MSG_FWDGETM};
                        dests  = {dests, own};
                        own    = req;
                        own_ok = 1'b1;
                    end
                    default: v = VERDICT_STALLED;
                endcase
            end
            FUNC_PUTS: begin
                if (st != DIR_I) begin
                    sh &= ~rbit;
                    if (st == DIR_S && sh == '0) st = DIR_I;
                end
                kinds = {kinds, MSG_PUTSACK};
                dests = {dests, req};
            end
            FUNC_PUTM: begin
                if (is_owner) begin
                    if (st == DIR_M) begin
                        kinds  = {kinds, MSG_PUTMACK};
                        dests  = {dests, req};
                        own_ok = 1'b0;
                        st     = DIR_I;
                    end else begin
                        v = VERDICT_UNEXPECTED;
                    end
                end else begin
                    if (st == DIR_S || st == DIR_SD) sh &= ~rbit;
                    kinds = {kinds, MSG_PUTMACK};
                    dests = {dests, req};
                end
            end
            FUNC_DATA: begin
                if (st == DIR_SD) st = DIR_S;
                else v = VERDICT_UNEXPECTED;
            end
            default: v = VERDICT_UNEXPECTED;
        endcase
        if (v == VERDICT_ADVANCED) begin
            mirror_state[line]    = st;
            mirror_sharers[line]  = sh;
            mirror_owner[line]    = own;
            mirror_owner_ok[line] = own_ok;
        end else begin
            kinds.delete();
            dests.delete();
        end
        if (kinds.size() == 0) begin
            kinds = {kinds, MSG_NONE};
            dests = {dests, 3'd0};
        end
        foreach (kinds[i]) begin
            m.verdict     = v;
            m.kind        = kinds[i];
            m.dest        = dests[i];
            m.last        = (i == kinds.size() - 1);
            expected_msgs = {expected_msgs, m};
        end
    endfunction

    function automatic logic [2:0] pick_sharer(input agent_vec_t sh);
        logic [2:0] r;
        r = 3'($urandom);
        if (sh != '0) begin
            while (!sh[r]) r = 3'($urandom);
        end
        return r;
    endfunction

    // mostly requests that make sense in the line's current state
    function automatic void pick_request(output logic [2:0] f, output logic [9:0] line,
                                         output logic [2:0] req);
        int         roll;
        agent_vec_t sh;
        line = ($urandom_range(0, 99) < 85) ? line_pool[$urandom_range(0, 5)] : 10'($urandom);
        req  = 3'($urandom);
        sh   = mirror_sharers[line];
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            f = 3'($urandom);
        end else begin
            case (mirror_state[line])
                DIR_I: begin
                    if (roll < 60) f = FUNC_GETS;
                    else if (roll < 85) f = FUNC_GETM;
                    else f = $urandom_range(0, 1) ? FUNC_PUTS : FUNC_PUTM;
                end
                DIR_S: begin
                    if (roll < 50) f = FUNC_GETS;
                    else if (roll < 70) f = FUNC_GETM;
                    else if (roll < 95) begin
                        f   = FUNC_PUTS;
                        req = pick_sharer(sh);
                    end else f = FUNC_PUTM;
                end
                DIR_M: begin
                    if (roll < 35) f = FUNC_GETS;
                    else if (roll < 60) f = FUNC_GETM;
                    else if (roll < 90) begin
                        f   = FUNC_PUTM;
                        req = mirror_owner[line];
                    end else f = $urandom_range(0, 1) ? FUNC_PUTS : FUNC_PUTM;
                end
                default: begin
                    if (roll < 70) f = FUNC_DATA;
                    else if (roll < 80) begin
                        f   = FUNC_PUTS;
                        req = pick_sharer(sh);
                    end else f = $urandom_range(0, 1) ? FUNC_GETS : FUNC_GETM;
                end
            endcase
        end
    endfunction

    task automatic send_request(input logic [2:0] f, input logic [9:0] line,
                                input logic [2:0] req);
        int gap;
        gap = src_idle ? $urandom_range(0, 5) : 0;
        @(negedge aclk);
        repeat (gap) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= f;
        s_line_index <= line;
        s_requester  <= req;
        do @(posedge aclk); while (!s_ready);
        predict_directory(f, line, req);
        n_requests++;
    endtask

    task automatic send_random(input int count);
        logic [2:0] f;
        logic [9:0] line;
        logic [2:0] req;
        repeat (count) begin
            pick_request(f, line, req);
            send_request(f, line, req);
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_msgs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_request(FUNC_GETS, LINE_LO, 3'd0);
        send_request(FUNC_GETS, LINE_LO, 3'd7);
        send_request(FUNC_GETM, LINE_LO, 3'd3);
        send_request(FUNC_GETS, LINE_LO, 3'd5);
        send_request(FUNC_GETS, LINE_LO, 3'd1);
        send_request(FUNC_GETM, LINE_LO, 3'd1);
        send_request(FUNC_PUTM, LINE_LO, 3'd5);
        send_request(FUNC_DATA, LINE_LO, 3'd0);
        send_request(FUNC_DATA, LINE_LO, 3'd2);
        send_request(FUNC_PUTS, LINE_LO, 3'd3);
        send_request(FUNC_PUTS, LINE_LO, 3'd3);
        for (int a = 0; a < NUM_AGENTS; a++) send_request(FUNC_GETS, LINE_HI, 3'(a));
        // full invalidation run to every agent
        send_request(FUNC_GETM, LINE_HI, 3'd2);
        send_request(FUNC_PUTM, LINE_HI, 3'd6);
        send_request(FUNC_GETM, LINE_HI, 3'd7);
        send_request(FUNC_PUTM, LINE_HI, 3'd7);
        send_request(3'd5, LINE_MID, 3'd0);
        send_request(3'd7, LINE_HI, 3'd7);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        for (int chunk = 0; chunk < 6; chunk++) begin
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            send_random(45);
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        wait_drained();
    endtask

    task automatic test_backpressure();
        sink_hold = HOLD_CYCLES;
        for (int a = 0; a < NUM_AGENTS; a++) send_request(FUNC_GETS, 10'd700, 3'(a));
        send_request(FUNC_GETM, 10'd700, 3'd4);
        send_random(11);
        wait_drained();
    endtask

    task automatic test_drain_pause();
        send_random(10);
        wait_drained();
        send_random(10);
        wait_drained();
    endtask

    function automatic void report_field(input string name, input int exp_v, input int act_v);
        n_errors++;
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
    endfunction

    always @(posedge aclk) begin : check_results
        dir_msg_t e;
        if (aresetn && m_valid && m_ready) begin
            sink_stall = sink_idle ? $urandom_range(0, 5) : 0;
            n_results++;
            run_len++;
            if (m_msg_kind == MSG_INV) n_inv++;
            if (m_last) begin
                if (m_verdict == VERDICT_STALLED) n_stall++;
                if (m_verdict == VERDICT_UNEXPECTED) n_unexp++;
                if (run_len > max_run) max_run = run_len;
                run_len = 0;
            end
            if (expected_msgs.size() == 0) begin
                n_errors++;
                $error("result with no request pending: kind %0d dest %0d",
                       m_msg_kind, m_dest_agent);
            end else begin
                e = expected_msgs.pop_front();
                if (m_verdict !== e.verdict) report_field("verdict", e.verdict, m_verdict);
                if (m_msg_kind !== e.kind) report_field("msg_kind", e.kind, m_msg_kind);
                if (m_dest_agent !== e.dest) report_field("dest_agent", e.dest, m_dest_agent);
                if (m_last !== e.last) report_field("last", e.last, m_last);
            end
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold > 0) begin
                m_ready <= 1'b0;
                sink_hold--;
            end else if (sink_stall > 0) begin
                m_ready <= 1'b0;
                sink_stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_func       = '0;
        s_line_index = '0;
        s_requester  = '0;
        for (int i = 0; i < NUM_LINES; i++) begin
            mirror_state[i]    = DIR_I;
            mirror_sharers[i]  = '0;
            mirror_owner[i]    = '0;
            mirror_owner_ok[i] = 1'b0;
        end
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_traffic();
        test_backpressure();
        test_drain_pause();
        $display("covered %0d requests, %0d results: %0d invalidations, %0d stalls, %0d unexpected",
                 n_requests, n_results, n_inv, n_stall, n_unexp);
        $display("longest message run %0d, one %0d-cycle receiver hold, sender drain pauses",
                 max_run, HOLD_CYCLES);
        if (n_errors == 0) begin
            $display("msi_directory_controller test passed");
        end else begin
            $display("msi_directory_controller test failed");
        end
        $finish;
    end

endmodule
